// ===== sv/trq_pkg.sv =====
// Shared types, codes and helpers of the ticketed ring queue.
package trq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned MAX_RESULTS   = 16;
   localparam int unsigned SIZE_W        = 5;
   localparam int unsigned DATA_W        = 32;

   typedef enum logic [1:0] {
      KIND_ENQ  = 2'd0,
      KIND_DEQ  = 2'd1,
      KIND_LIST = 2'd2
   } trq_kind_type;

   typedef enum logic [2:0] {
      STAT_ISSUED     = 3'd0,
      STAT_FULL       = 3'd1,
      STAT_SERVED     = 3'd2,
      STAT_EMPTY      = 3'd3,
      STAT_LIST       = 3'd4,
      STAT_LIST_EMPTY = 3'd5
   } trq_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SERVE,
      ST_WALK
   } trq_state_type;

   typedef struct packed {
      trq_kind_type        kind;
      logic [DATA_W-1:0]   name_tag;
   } trq_req_type;

   typedef struct packed {
      trq_status_type      status;
      logic [DATA_W-1:0]   ticket;
      logic [DATA_W-1:0]   tag_out;
      logic                last;
   } trq_rsp_type;

   // Size register value clamped to 1..depth.
   function automatic int unsigned trq_active_size(input int unsigned qs,
                                                   input int unsigned depth);
      int unsigned s;
      s = qs;
      if (s < 1) s = 1;
      if (s > depth) s = depth;
      return s;
   endfunction

endpackage

// ===== sv/trq_ram.sv =====
// Entry store: one write port, one read port with registered read data.
module trq_ram #(
   parameter int unsigned DEPTH = trq_pkg::DEPTH_DEFAULT,
   parameter int unsigned WIDTH = 2 * trq_pkg::DATA_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ticketed_ring_queue.sv =====
// Top level of the ticketed ring queue: control, pointers and size register.
//
// Ticketed ring queue. Request beats on req_* carry a kind and a name tag;
// result beats on rsp_* carry status, ticket, tag and a last flag. Both
// channels are valid/ready. The APB-style csr_* port holds queue_size at
// byte address 0; writing it empties the queue and restarts tickets at 1.
// Configure only while the block is idle.
//
// Request handling: an enqueue, or any full/empty answer, lands in
// the output register at the accept edge. A dequeue reads the entry
// store and delivers in the cycle after. A list walks the occupied
// entries, one store read per result beat, for at most MAX_RESULTS
// entries. The single read port of the entry store paces the dequeue
// and the walk. One request is in flight at a time; a kind of 3 is
// accepted and dropped.
//
// Reset: queue empty, head 0, tail size-1, next ticket 1, size DEPTH.
// The entry store is not cleared; only written entries are ever read.
// Receiver stall: the output register holds its beat; the walk and new
// requests wait until that beat is taken.
module ticketed_ring_queue #(
   parameter int unsigned DEPTH = trq_pkg::DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  trq_pkg::trq_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output trq_pkg::trq_rsp_type rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int unsigned IW   = $clog2(DEPTH);
   localparam int unsigned ASW  = $clog2(DEPTH + 1);
   localparam int unsigned QS_W = (ASW > trq_pkg::SIZE_W) ? ASW : trq_pkg::SIZE_W;
   localparam int unsigned CW   = $clog2(trq_pkg::MAX_RESULTS);
   localparam int unsigned DW   = trq_pkg::DATA_W;

   // control state
   trq_pkg::trq_state_type state_ff, state_in;
   logic [QS_W-1:0]  size_ff, size_in;
   logic [IW-1:0]    head_ff, head_in;
   logic [IW-1:0]    tail_ff, tail_in;
   logic [ASW-1:0]   occ_ff, occ_in;
   logic [DW-1:0]    ticket_ff, ticket_in;
   logic [IW-1:0]    walk_idx_ff, walk_idx_in;
   logic [CW-1:0]    walk_cnt_ff, walk_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   // output payload
   trq_pkg::trq_rsp_type rsp_ff, rsp_in;

   logic [ASW-1:0]   act_size;
   logic [ASW-1:0]   new_size;
   logic             out_free;
   logic             accept;
   logic             csr_wr;

   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [2*DW-1:0]  wr_data;
   logic             rd_en;
   logic [IW-1:0]    rd_addr;
   logic [2*DW-1:0]  rd_data;

   function automatic logic [IW-1:0] advance(input logic [IW-1:0] i,
                                             input logic [ASW-1:0] sz);
      logic [ASW-1:0] n;
      n = ASW'(i) + ASW'(1);
      return (n >= sz) ? '0 : n[IW-1:0];
   endfunction

   trq_ram #(
      .DEPTH (DEPTH),
      .WIDTH (2 * DW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign act_size = ASW'(trq_pkg::trq_active_size(32'(size_ff), DEPTH));
   assign new_size = ASW'(trq_pkg::trq_active_size(32'(csr_pwdata[trq_pkg::SIZE_W-1:0]),
                                                   DEPTH));

   // register 0 lives in the low word; bit 2 set is outside the map
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(size_ff);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == trq_pkg::ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      int unsigned n;
      logic [IW-1:0] slot;
      n            = 32'(occ_ff);
      if (n > trq_pkg::MAX_RESULTS) n = trq_pkg::MAX_RESULTS;
      slot         = advance(tail_ff, act_size);

      state_in     = state_ff;
      size_in      = size_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      ticket_in    = ticket_ff;
      walk_idx_in  = walk_idx_ff;
      walk_cnt_in  = walk_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      wr_en   = 1'b0;
      wr_addr = slot;
      wr_data = {ticket_ff, req_data.name_tag};
      rd_en   = 1'b0;
      rd_addr = head_ff;

      if (csr_wr) begin
         // size write empties the queue
         size_in   = QS_W'(csr_pwdata[trq_pkg::SIZE_W-1:0]);
         head_in   = '0;
         tail_in   = IW'(new_size - ASW'(1));
         occ_in    = '0;
         ticket_in = DW'(1);
      end else begin
         unique case (state_ff)
            trq_pkg::ST_IDLE: begin
               if (accept) begin
                  rsp_in.ticket  = '0;
                  rsp_in.tag_out = '0;
                  rsp_in.last    = 1'b1;
                  unique case (req_data.kind)
                     trq_pkg::KIND_ENQ: begin
                        rsp_valid_in = 1'b1;
                        if (occ_ff >= act_size) begin
                           rsp_in.status = trq_pkg::STAT_FULL;
                        end else begin
                           wr_en          = 1'b1;
                           tail_in        = slot;
                           ticket_in      = ticket_ff + DW'(1);
                           occ_in         = occ_ff + ASW'(1);
                           rsp_in.status  = trq_pkg::STAT_ISSUED;
                           rsp_in.ticket  = ticket_ff;
                           rsp_in.tag_out = req_data.name_tag;
                        end
                     end
                     trq_pkg::KIND_DEQ: begin
                        if (occ_ff == '0) begin
                           rsp_valid_in  = 1'b1;
                           rsp_in.status = trq_pkg::STAT_EMPTY;
                        end else begin
                           rd_en    = 1'b1;
                           head_in  = advance(head_ff, act_size);
                           occ_in   = occ_ff - ASW'(1);
                           state_in = trq_pkg::ST_SERVE;
                        end
                     end
                     trq_pkg::KIND_LIST: begin
                        if (occ_ff == '0) begin
                           rsp_valid_in  = 1'b1;
                           rsp_in.status = trq_pkg::STAT_LIST_EMPTY;
                        end else begin
                           rd_en       = 1'b1;
                           walk_idx_in = advance(head_ff, act_size);
                           walk_cnt_in = CW'(n - 1);
                           state_in    = trq_pkg::ST_WALK;
                        end
                     end
                     default: begin
                        // unused kind: beat dropped, no result
                     end
                  endcase
               end
            end
            trq_pkg::ST_SERVE: begin
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.status  = trq_pkg::STAT_SERVED;
                  rsp_in.ticket  = rd_data[2*DW-1:DW];
                  rsp_in.tag_out = rd_data[DW-1:0];
                  rsp_in.last    = 1'b1;
                  state_in       = trq_pkg::ST_IDLE;
               end
            end
            trq_pkg::ST_WALK: begin
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.status  = trq_pkg::STAT_LIST;
                  rsp_in.ticket  = rd_data[2*DW-1:DW];
                  rsp_in.tag_out = rd_data[DW-1:0];
                  rsp_in.last    = (walk_cnt_ff == '0);
                  if (walk_cnt_ff == '0) begin
                     state_in = trq_pkg::ST_IDLE;
                  end else begin
                     // fetch the next entry while this beat goes out
                     rd_en       = 1'b1;
                     rd_addr     = walk_idx_ff;
                     walk_idx_in = advance(walk_idx_ff, act_size);
                     walk_cnt_in = walk_cnt_ff - CW'(1);
                  end
               end
            end
            default: begin
               state_in = trq_pkg::ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trq_pkg::ST_IDLE;
         size_ff      <= QS_W'(DEPTH);
         head_ff      <= '0;
         tail_ff      <= IW'(DEPTH - 1);
         occ_ff       <= '0;
         ticket_ff    <= DW'(1);
         walk_idx_ff  <= '0;
         walk_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         ticket_ff    <= ticket_in;
         walk_idx_ff  <= walk_idx_in;
         walk_cnt_ff  <= walk_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the ticketed ring queue: directed table, then random phases.
module tb_top;

   // Sizes and timing of the run
   localparam int unsigned RING_DEPTH   = trq_pkg::DEPTH_DEFAULT;
   localparam int unsigned RANDOM_ITEMS = 500;
   localparam int unsigned QUIET_AFTER  = 440;    // no idling past this many random beats
   localparam int unsigned SETTLE_CYCLES = trq_pkg::MAX_RESULTS + 4;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned REPORT_MAX   = 10;

   // The one kind without a name in the package: accepted and dropped
   localparam logic [1:0] KIND_DROP = 2'd3;
   // Byte address of queue_size on the register port
   localparam logic [2:0] ADDR_QUEUE_SIZE = 3'd0;

   // One row of the directed table: either a size write or a request beat.
   // Where typed is set, the single expected answer is written out in the row.
   typedef struct packed {
      logic                 is_cfg;
      logic [4:0]           cfg_val;
      logic [1:0]           kind;
      logic [31:0]          tag;
      logic                 typed;
      trq_pkg::trq_rsp_type answer;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   trq_pkg::trq_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   trq_pkg::trq_rsp_type rsp_data;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [2:0]           csr_paddr;
   logic [31:0]          csr_pwdata;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   ticketed_ring_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Mirror of the queue: slots, pointers, fill level, ticket counter, live size
   logic [31:0]   ring_ticket [RING_DEPTH];
   logic [31:0]   ring_tag    [RING_DEPTH];
   int unsigned   ring_head;
   int unsigned   ring_tail;
   int unsigned   ring_count;
   int unsigned   ring_size;
   logic [31:0]   ticket_counter;

   // Answers still owed by the block, oldest first
   trq_pkg::trq_rsp_type pending_answers [$];
   stim_row_type         stim_table [$];

   int unsigned   mismatches;
   int unsigned   cycle_count;
   int unsigned   ready_hold;
   bit            quiet;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Run guard: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ----------------------------------------------------------------------
   // Mirror of the block
   // ----------------------------------------------------------------------

   // Ring index step within the live size
   function automatic int unsigned next_slot(input int unsigned idx);
      int unsigned n;
      n = idx + 1;
      return (n >= ring_size) ? 0 : n;
   endfunction

   // A size write: 0 acts as 1, anything above the depth acts as the depth.
   // Every write empties the queue and restarts tickets at 1.
   function automatic void apply_queue_size(input logic [4:0] raw);
      if (raw == 5'd0)
         ring_size = 1;
      else if (raw > RING_DEPTH)
         ring_size = RING_DEPTH;
      else
         ring_size = 32'(raw);
      ring_head      = 0;
      ring_tail      = ring_size - 1;
      ring_count     = 0;
      ticket_counter = 32'd1;
   endfunction

   // Works out the answers to one accepted request and queues them
   function automatic void predict_answers(input logic [1:0] kind, input logic [31:0] tag);
      int unsigned walk;
      int unsigned count;
      int unsigned c;
      trq_pkg::trq_rsp_type ans;
      ans      = '0;
      ans.last = 1'b1;
      case (kind)
         trq_pkg::KIND_ENQ: begin
            if (ring_count >= ring_size) begin
               ans.status = trq_pkg::STAT_FULL;
            end else begin
               ring_tail = next_slot(ring_tail);
               ring_tag[ring_tail]    = tag;
               ring_ticket[ring_tail] = ticket_counter;
               ans.status  = trq_pkg::STAT_ISSUED;
               ans.ticket  = ticket_counter;
               ans.tag_out = tag;
               ticket_counter = ticket_counter + 32'd1;
               ring_count++;
            end
            pending_answers.push_back(ans);
         end
         trq_pkg::KIND_DEQ: begin
            if (ring_count == 0) begin
               ans.status = trq_pkg::STAT_EMPTY;
            end else begin
               ans.status  = trq_pkg::STAT_SERVED;
               ans.ticket  = ring_ticket[ring_head];
               ans.tag_out = ring_tag[ring_head];
               ring_count--;
               ring_head = next_slot(ring_head);
            end
            pending_answers.push_back(ans);
         end
         trq_pkg::KIND_LIST: begin
            if (ring_count == 0) begin
               ans.status = trq_pkg::STAT_LIST_EMPTY;
               pending_answers.push_back(ans);
            end else begin
               // oldest to newest, capped; the queue itself is left alone
               count = (ring_count > trq_pkg::MAX_RESULTS) ? trq_pkg::MAX_RESULTS
                                                           : ring_count;
               walk  = ring_head;
               for (c = 0; c < count; c++) begin
                  ans.status  = trq_pkg::STAT_LIST;
                  ans.ticket  = ring_ticket[walk];
                  ans.tag_out = ring_tag[walk];
                  ans.last    = (c + 1 == count);
                  pending_answers.push_back(ans);
                  walk = next_slot(walk);
               end
            end
         end
         default: begin
            // kind 3: dropped, no answer, no state change
         end
      endcase
   endfunction

   // ----------------------------------------------------------------------
   // Result side: random stalls, and the checker
   // ----------------------------------------------------------------------

   // Ready comes in random high and low runs. Always high once quiet.
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(1, 11) - 1;
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(1, 20) - 1;
      end
   end

   // Every result beat is matched against the oldest owed answer
   always @(posedge clock) begin
      trq_pkg::trq_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < REPORT_MAX)
               $display("unexpected beat: status %0d ticket %0d tag %h last %0b",
                        rsp_data.status, rsp_data.ticket, rsp_data.tag_out, rsp_data.last);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.status !== want.status || rsp_data.ticket !== want.ticket ||
                rsp_data.tag_out !== want.tag_out || rsp_data.last !== want.last) begin
               mismatches <= mismatches + 1;
               if (mismatches < REPORT_MAX)
                  $display({"beat mismatch: want status %0d ticket %0d tag %h last %0b,",
                            " got status %0d ticket %0d tag %h last %0b"},
                           want.status, want.ticket, want.tag_out, want.last,
                           rsp_data.status, rsp_data.ticket, rsp_data.tag_out,
                           rsp_data.last);
            end
         end
      end
   end

   // ----------------------------------------------------------------------
   // Request side
   // ----------------------------------------------------------------------

   // Optional idle burst ahead of a beat; valid drops only here and in wait_for_answers
   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Presents one beat and holds it until taken; valid stays high afterward
   // so back-to-back beats need no second assignment in one step.
   task automatic send_request(input logic [1:0] kind, input logic [31:0] tag,
                               input logic typed, input trq_pkg::trq_rsp_type answer);
      req_valid <= 1'b1;
      req_data  <= trq_pkg::trq_req_type'({kind, tag});
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      predict_answers(kind, tag);
      // a typed row carries its own answer in place of the mirrored one
      if (typed)
         pending_answers[pending_answers.size() - 1] = answer;
   endtask

   // Lets every owed beat arrive, then a settle margin for a dropped beat
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup and access phase register write; only called with the block idle
   task automatic write_queue_size(input logic [4:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_QUEUE_SIZE;
      csr_pwdata  <= {27'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready) break;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      apply_queue_size(value);
   endtask

   function automatic stim_row_type req_row(input logic [1:0] kind, input logic [31:0] tag,
                                            input logic typed,
                                            input trq_pkg::trq_status_type st,
                                            input logic [31:0] tkt, input logic [31:0] tg);
      stim_row_type r;
      r = '0;
      r.kind   = kind;
      r.tag    = tag;
      r.typed  = typed;
      r.answer = '{status: st, ticket: tkt, tag_out: tg, last: 1'b1};
      return r;
   endfunction

   function automatic stim_row_type cfg_row(input logic [4:0] value);
      stim_row_type r;
      r = '0;
      r.is_cfg  = 1'b1;
      r.cfg_val = value;
      return r;
   endfunction

   // ----------------------------------------------------------------------
   // Main sequence
   // ----------------------------------------------------------------------
   initial begin
      logic [4:0]    size_pick;
      logic [1:0]    kind;
      logic [31:0]   tag;
      int unsigned   random_beats;
      int unsigned   phase;
      int unsigned   phase_len;
      int unsigned   beat;
      int unsigned   mode;
      int unsigned   roll;
      logic [4:0]    size_extremes [6];

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      mismatches  = 0;
      cycle_count = 0;
      ready_hold  = 0;
      quiet       = 1'b0;
      size_extremes = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd2, 5'd17};
      apply_queue_size(5'd16);    // reset value: full depth

      // Directed table. Starts at the reset size, 16.
      // empty answers right after reset
      stim_table.push_back(req_row(trq_pkg::KIND_DEQ, 32'h0, 1'b1,
                                   trq_pkg::STAT_EMPTY, 32'd0, 32'd0));
      stim_table.push_back(req_row(trq_pkg::KIND_LIST, 32'h0, 1'b1,
                                   trq_pkg::STAT_LIST_EMPTY, 32'd0, 32'd0));
      // tag extremes; tickets start at 1
      stim_table.push_back(req_row(trq_pkg::KIND_ENQ, 32'h0000_0000, 1'b1,
                                   trq_pkg::STAT_ISSUED, 32'd1, 32'h0));
      stim_table.push_back(req_row(trq_pkg::KIND_ENQ, 32'hFFFF_FFFF, 1'b1,
                                   trq_pkg::STAT_ISSUED, 32'd2, 32'hFFFF_FFFF));
      // unknown kind is dropped without an answer
      stim_table.push_back(req_row(KIND_DROP, 32'hA5A5_5A5A, 1'b0,
                                   trq_pkg::STAT_ISSUED, 32'd0, 32'd0));
      stim_table.push_back(req_row(trq_pkg::KIND_LIST, 32'h0, 1'b0,
                                   trq_pkg::STAT_ISSUED, 32'd0, 32'd0));
      stim_table.push_back(req_row(trq_pkg::KIND_DEQ, 32'h0, 1'b1,
                                   trq_pkg::STAT_SERVED, 32'd1, 32'h0));
      stim_table.push_back(req_row(trq_pkg::KIND_DEQ, 32'h0, 1'b1,
                                   trq_pkg::STAT_SERVED, 32'd2, 32'hFFFF_FFFF));
      stim_table.push_back(req_row(trq_pkg::KIND_DEQ, 32'h0, 1'b1,
                                   trq_pkg::STAT_EMPTY, 32'd0, 32'd0));
      // one-slot ring: full after a single entry
      stim_table.push_back(cfg_row(5'd1));
      stim_table.push_back(req_row(trq_pkg::KIND_ENQ, 32'h1234_5678, 1'b1,
                                   trq_pkg::STAT_ISSUED, 32'd1, 32'h1234_5678));
      stim_table.push_back(req_row(trq_pkg::KIND_ENQ, 32'h0BAD_F00D, 1'b1,
                                   trq_pkg::STAT_FULL, 32'd0, 32'd0));
      stim_table.push_back(req_row(trq_pkg::KIND_LIST, 32'h0, 1'b0,
                                   trq_pkg::STAT_ISSUED, 32'd0, 32'd0));
      stim_table.push_back(req_row(trq_pkg::KIND_DEQ, 32'h0, 1'b1,
                                   trq_pkg::STAT_SERVED, 32'd1, 32'h1234_5678));
      stim_table.push_back(req_row(trq_pkg::KIND_ENQ, 32'h0000_0001, 1'b0,
                                   trq_pkg::STAT_ISSUED, 32'd0, 32'd0));
      // size 0 behaves as 1
      stim_table.push_back(cfg_row(5'd0));
      stim_table.push_back(req_row(trq_pkg::KIND_ENQ, 32'h8000_0000, 1'b1,
                                   trq_pkg::STAT_ISSUED, 32'd1, 32'h8000_0000));
      stim_table.push_back(req_row(trq_pkg::KIND_ENQ, 32'h7FFF_FFFF, 1'b1,
                                   trq_pkg::STAT_FULL, 32'd0, 32'd0));
      stim_table.push_back(req_row(trq_pkg::KIND_DEQ, 32'h0, 1'b1,
                                   trq_pkg::STAT_SERVED, 32'd1, 32'h8000_0000));
      // size above the depth behaves as the depth
      stim_table.push_back(cfg_row(5'd31));
      stim_table.push_back(req_row(trq_pkg::KIND_ENQ, 32'h5555_5555, 1'b1,
                                   trq_pkg::STAT_ISSUED, 32'd1, 32'h5555_5555));
      stim_table.push_back(req_row(trq_pkg::KIND_ENQ, 32'hAAAA_AAAA, 1'b1,
                                   trq_pkg::STAT_ISSUED, 32'd2, 32'hAAAA_AAAA));
      stim_table.push_back(req_row(trq_pkg::KIND_DEQ, 32'h0, 1'b1,
                                   trq_pkg::STAT_SERVED, 32'd1, 32'h5555_5555));
      stim_table.push_back(req_row(trq_pkg::KIND_LIST, 32'h0, 1'b0,
                                   trq_pkg::STAT_ISSUED, 32'd0, 32'd0));
      stim_table.push_back(req_row(KIND_DROP, 32'hFFFF_FFFF, 1'b0,
                                   trq_pkg::STAT_ISSUED, 32'd0, 32'd0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i]) begin
         if (stim_table[i].is_cfg) begin
            wait_for_answers();
            write_queue_size(stim_table[i].cfg_val);
         end else begin
            maybe_gap();
            send_request(stim_table[i].kind, stim_table[i].tag,
                         stim_table[i].typed, stim_table[i].answer);
         end
      end

      // Random phases. Each phase starts from an idle block with a new size,
      // the extremes first. A phase leans toward filling, draining or a mix,
      // so full rings, full-length lists and wraparound all come up often.
      random_beats = 0;
      phase        = 0;
      while (random_beats < RANDOM_ITEMS) begin
         wait_for_answers();
         size_pick = (phase < 6) ? size_extremes[phase] : 5'($urandom_range(0, 31));
         write_queue_size(size_pick);
         phase_len = $urandom_range(15, 50);
         mode      = $urandom_range(0, 2);
         for (beat = 0; beat < phase_len && random_beats < RANDOM_ITEMS; beat++) begin
            if (random_beats >= QUIET_AFTER)
               quiet = 1'b1;
            // one mid-phase hold-off until the block has caught up
            if (phase == 3 && beat == phase_len / 2)
               wait_for_answers();
            roll = $urandom_range(0, 99);
            if (roll < 3)
               kind = KIND_DROP;
            else if (mode == 0)
               kind = (roll < 65) ? trq_pkg::KIND_ENQ :
                      (roll < 85) ? trq_pkg::KIND_DEQ : trq_pkg::KIND_LIST;
            else if (mode == 1)
               kind = (roll < 25) ? trq_pkg::KIND_ENQ :
                      (roll < 85) ? trq_pkg::KIND_DEQ : trq_pkg::KIND_LIST;
            else
               kind = (roll < 42) ? trq_pkg::KIND_ENQ :
                      (roll < 82) ? trq_pkg::KIND_DEQ : trq_pkg::KIND_LIST;
            case ($urandom_range(0, 7))
               0:       tag = 32'h0000_0000;
               1:       tag = 32'hFFFF_FFFF;
               default: tag = $urandom;
            endcase
            maybe_gap();
            send_request(kind, tag, 1'b0, '0);
            if (kind != KIND_DROP)
               random_beats++;
         end
         phase++;
      end

      // Drain and settle, then the verdict
      wait_for_answers();
      if (pending_answers.size() != 0)
         mismatches = mismatches + 1;
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
